>>> sv/hash_set_membership_macros.svh
// Assertion macros used by the top-level file to check this block.
`ifndef HASH_SET_MEMBERSHIP_MACROS_SVH
`define HASH_SET_MEMBERSHIP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hsm_pkg.sv
package hsm_pkg;

    // Fixed field widths of the channels.
    localparam int CMD_W      = 2;
    localparam int KEY_PORT_W = 32;
    localparam int COUNT_W    = 11;
    localparam int BYTE_W     = 8;

    // Hash multiplier and the number of key bytes that carry data.
    localparam int HASH_MULT      = 31;
    localparam int KEY_DATA_BYTES = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic               refused;
        logic [COUNT_W-1:0] element_count;
    } t_result;

endpackage

>>> sv/hsm_fifo.sv
module hsm_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    // Two-entry queue between the hash front and the bucket back.
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/hsm_front.sv
module hsm_front #(
    parameter int NUM_BUCKETS = 256,
    parameter int KEY_BYTES   = 4,
    parameter int H_W         = 8,
    parameter int KEY_W       = 32,
    parameter int Q_W         = 42
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_busy,
    input  logic [hsm_pkg::CMD_W-1:0]     i_command,
    input  logic [hsm_pkg::KEY_PORT_W-1:0] i_key,
    output logic                          o_q_push,
    output logic [Q_W-1:0]                o_q_data,
    input  logic                          i_q_full
);

    import hsm_pkg::*;

    // Widest value of 31*h + byte, and the reciprocal used to reduce it.
    localparam int X_W = $clog2(HASH_MULT * (NUM_BUCKETS - 1) + 256);
    localparam longint unsigned RECIP =
        (64'd4294967296 + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam int STEP_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_RED, F_PUSH} t_fstate;

    t_fstate             r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    r_shift;
    logic [H_W-1:0]      r_h;
    logic [X_W-1:0]      r_x;
    logic [X_W-1:0]      r_q;
    logic [STEP_W-1:0]   r_step;

    logic [BYTE_W-1:0]   hash_byte;
    logic [X_W-1:0]      x_val;
    logic [X_W+31:0]     prod;
    logic [X_W-1:0]      q_val;
    logic [X_W:0]        qn;
    logic [X_W:0]        diff;
    logic [X_W:0]        rem;
    logic [H_W-1:0]      n_h;

    // Hash step, first half: x = 31*h + byte and its estimated quotient by the bucket count.
    // Second half: remainder x - q*N with one correction for an estimate one too high.
    always_comb begin
        hash_byte = r_shift[BYTE_W-1:0];
        x_val     = X_W'(r_h) * X_W'(HASH_MULT) + X_W'(hash_byte);
        prod      = (X_W+32)'(x_val) * (X_W+32)'(RECIP);
        q_val     = prod[X_W+31:32];
        qn        = (X_W+1)'(r_q) * (X_W+1)'(NUM_BUCKETS);
        diff      = {1'b0, r_x} - qn;
        rem       = diff[X_W] ? (diff + (X_W+1)'(NUM_BUCKETS)) : diff;
        n_h       = H_W'(rem);
    end

    // Sequencer: each key byte passes through F_MUL and then F_RED, then hand the transaction to the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_cmd   <= i_command;
                        r_key   <= KEY_W'(i_key);
                        r_shift <= KEY_W'(i_key);
                        r_h     <= '0;
                        r_step  <= '0;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_x     <= x_val;
                    r_q     <= q_val;
                    r_shift <= r_shift >> BYTE_W;
                    r_state <= F_RED;
                end
                F_RED: begin
                    r_h <= n_h;
                    if (r_step == STEP_W'(KEY_BYTES - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= F_MUL;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = {r_cmd, r_h, r_key};

endmodule

>>> sv/hsm_back.sv
module hsm_back #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 4,
    parameter int H_W         = 8,
    parameter int KEY_W       = 32,
    parameter int Q_W         = 42,
    parameter int WAY_W       = 2,
    parameter int CNT_W       = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  logic [Q_W-1:0]   i_q_data,
    output logic             o_q_pop,
    output logic             o_clearing,
    output logic             o_out_valid,
    input  logic             i_pop,
    output hsm_pkg::t_result o_result
);

    import hsm_pkg::*;

    localparam int ROW_W = BUCKET_WAYS * KEY_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CMP} t_bstate;

    // Bucket rows: keys are written before they are ever read as valid,
    // so only the valid rows are swept after reset.
    logic [ROW_W-1:0]       key_mem   [NUM_BUCKETS];
    logic [BUCKET_WAYS-1:0] valid_mem [NUM_BUCKETS];

    t_bstate                r_state;
    logic [H_W-1:0]         r_clr_idx;
    logic [CMD_W-1:0]       r_cmd;
    logic [H_W-1:0]         r_addr;
    logic [KEY_W-1:0]       r_key;
    logic [ROW_W-1:0]       r_rd_row;
    logic [BUCKET_WAYS-1:0] r_rd_valid;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    t_result                r_result;

    logic                   hit;
    logic [WAY_W-1:0]       hit_way;
    logic                   free;
    logic [WAY_W-1:0]       free_way;
    logic                   refused;
    logic                   row_write;
    logic [ROW_W-1:0]       n_key_row;
    logic [BUCKET_WAYS-1:0] n_valid_row;
    logic [CNT_W-1:0]       n_count;
    logic                   commit;
    logic                   v_we;
    logic [H_W-1:0]         v_addr;
    logic [BUCKET_WAYS-1:0] v_data;

    // Parallel compare over the ways; the lowest matching and lowest free way win.
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!hit && r_rd_valid[w] && (r_rd_row[w*KEY_W +: KEY_W] == r_key)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!free && !r_rd_valid[w]) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // Command decode and the updated bucket row.
    always_comb begin
        n_key_row   = r_rd_row;
        n_valid_row = r_rd_valid;
        n_count     = r_count;
        refused     = 1'b0;
        row_write   = 1'b0;
        unique case (t_cmd'(r_cmd))
            CMD_ADD: begin
                if (!hit) begin
                    if (free) begin
                        n_valid_row[free_way]              = 1'b1;
                        n_key_row[free_way*KEY_W +: KEY_W] = r_key;
                        n_count                            = r_count + CNT_W'(1);
                        row_write                          = 1'b1;
                    end else begin
                        refused = 1'b1;
                    end
                end
            end
            CMD_DELETE: begin
                if (hit) begin
                    n_valid_row[hit_way] = 1'b0;
                    n_count              = r_count - CNT_W'(1);
                    row_write            = 1'b1;
                end
            end
            default: begin
                // Query and the unused code change nothing.
            end
        endcase
    end

    assign commit = (r_state == S_CMP) && (!r_out_valid || i_pop);

    // Valid-row write port is shared by the clearing sweep and the updates.
    always_comb begin
        if (r_state == S_CLEAR) begin
            v_we   = 1'b1;
            v_addr = r_clr_idx;
            v_data = '0;
        end else begin
            v_we   = commit && row_write;
            v_addr = r_addr;
            v_data = n_valid_row;
        end
    end

    // Bucket memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            valid_mem[v_addr] <= v_data;
        end
        if (commit && row_write) begin
            key_mem[r_addr] <= n_key_row;
        end
        r_rd_row   <= key_mem[r_addr];
        r_rd_valid <= valid_mem[r_addr];
    end

    // Control: clear sweep, take a transaction, read its bucket, update and report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + H_W'(1);
                    if (r_clr_idx == H_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        {r_cmd, r_addr, r_key} <= i_q_data;
                        r_state                <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (commit) begin
                        r_count                <= n_count;
                        r_result.found         <= hit;
                        r_result.refused       <= refused;
                        r_result.element_count <=
                            COUNT_W'((CNT_W + COUNT_W)'(n_count));
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

>>> sv/hash_set_membership.sv
// Hash set of keys with NUM_BUCKETS buckets of BUCKET_WAYS ways each.
// Input channel: a transaction (i_command, i_key) is taken on a clock edge with
// push high and full low. Commands are query, add and delete; the unused code
// behaves as a query.
// Result channel: while empty is low the oldest result (o_found, o_refused,
// o_element_count) is on the ports; pop with empty low takes it.
// The front computes the bucket index one key byte at a time, through its
// multiply and reduce states, and takes no new transaction until the last one
// is in the queue; this hash loop sets the throughput. A two-entry queue feeds
// the back, which pops in S_IDLE, reads the bucket row in S_READ, and compares
// and writes back in S_CMP.
// After reset the valid rows are swept, one bucket a cycle, through all NUM_BUCKETS
// buckets; full stays high and empty stays high during that time.
// When the receiver does not pop, the held result blocks the back, the queue
// fills, and full rises; no transaction is lost.
`include "hash_set_membership_macros.svh"

module hash_set_membership #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 4,
    parameter int KEY_BYTES   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [hsm_pkg::CMD_W-1:0]      i_command,
    input  logic [hsm_pkg::KEY_PORT_W-1:0] i_key,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_found,
    output logic                           o_refused,
    output logic [hsm_pkg::COUNT_W-1:0]    o_element_count
);

    import hsm_pkg::*;

    localparam int H_W   = $clog2(NUM_BUCKETS);
    localparam int KEY_W = BYTE_W * ((KEY_BYTES < KEY_DATA_BYTES) ? KEY_BYTES : KEY_DATA_BYTES);
    localparam int Q_W   = CMD_W + H_W + KEY_W;
    localparam int WAY_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int CNT_W = $clog2(NUM_BUCKETS * BUCKET_WAYS + 1);

    logic           front_busy;
    logic           front_push;
    logic           q_push;
    logic [Q_W-1:0] q_wdata;
    logic           q_full;
    logic           q_pop;
    logic [Q_W-1:0] q_rdata;
    logic           q_empty;
    logic           clearing;
    logic           out_valid;
    t_result        result;

    // No transaction is taken while the bucket rows are being cleared.
    assign front_push = push && !clearing;
    assign full       = front_busy || clearing;

    hsm_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_BYTES   (KEY_BYTES),
        .H_W         (H_W),
        .KEY_W       (KEY_W),
        .Q_W         (Q_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (front_push),
        .o_busy    (front_busy),
        .i_command (i_command),
        .i_key     (i_key),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata),
        .i_q_full  (q_full)
    );

    hsm_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    hsm_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS),
        .H_W         (H_W),
        .KEY_W       (KEY_W),
        .Q_W         (Q_W),
        .WAY_W       (WAY_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (out_valid),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign empty           = !out_valid;
    assign o_found         = result.found;
    assign o_refused       = result.refused;
    assign o_element_count = result.element_count;

    // A refused add can only happen for a key that was absent.
    `HSM_ASSERT_IMP(a_refused_absent, i_clk, i_rst_n, !empty && o_refused, !o_found, "refused add reported a present key")
    // During the clearing sweep nothing enters and no result is shown.
    `HSM_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, clearing, full && empty && q_empty, "activity during the clearing sweep")
    // The front never pushes into a full queue.
    `HSM_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, q_push, !q_full, "queue overflow")
    // A pop from the queue starts a bucket read, so the back cannot pop twice in a row.
    `HSM_ASSERT_NXT(a_back_single_pop, i_clk, i_rst_n, q_pop, !q_pop, "back popped two transactions in a row")

endmodule
